/* hdl/keypad_code_lock_controller_unit_defines.svh */
// ---------------------------------------------------------------------------
// Keypad code lock: assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_UNIT_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge outside reset
`define KCLC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define KCLC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define KCLC_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCLC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* hdl/kclc_pkg.sv */
// ---------------------------------------------------------------------------
// Keypad code lock package
// Key codes, session modes, status codes, state record and reset values.
// ---------------------------------------------------------------------------
package kclc_pkg;

	localparam int KEY_W     = 4;
	localparam int CODE_W    = 16;
	localparam int DCNT_W    = 3;   // holds up to eight keys of a session
	localparam int FAIL_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// keypad letters and the hash key
	localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
	localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
	localparam logic [KEY_W-1:0] KEY_C    = 4'd12;
	localparam logic [KEY_W-1:0] KEY_D    = 4'd13;
	localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EMERG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

	// reset values and the failure count ceiling
	localparam logic [CODE_W-1:0] EMERG_RST  = 16'h9999;
	localparam logic [CODE_W-1:0] STORED_RST = 16'h1234;
	localparam logic [FAIL_W-1:0] LIMIT_RST  = 4'd2;
	localparam logic [FAIL_W-1:0] FAIL_MAX   = 4'hF;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_OTP     = 3'd1,
		M_EMERG   = 3'd2,
		M_EMPASS  = 3'd3,
		M_CURPASS = 3'd4,
		M_NEWC    = 3'd5,
		M_DOTP    = 3'd6,
		M_NEWD    = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_UNLOCK  = 3'd1,
		ST_LOCKED  = 3'd2,
		ST_WRONG   = 3'd3,
		ST_LOCKOUT = 3'd4,
		ST_EMOK    = 3'd5,
		ST_NEWPASS = 3'd6,
		ST_CHANGED = 3'd7
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [DCNT_W-1:0]  dcnt;
		logic [CODE_W-1:0]  entry;
		logic [CODE_W-1:0]  expect_code;
		logic [CODE_W-1:0]  stored;
		logic [FAIL_W-1:0]  fails;
		logic               door;
	} lock_state_t;

endpackage

/* hdl/kclc_in_if.sv */
// ---------------------------------------------------------------------------
// Keypad code lock input channel
// One key beat with the one-time code that goes with it.
// ---------------------------------------------------------------------------
interface kclc_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  key;
	logic [15:0] fresh_code;

	modport source (output valid, output key, output fresh_code, input ready);
	modport sink   (input valid, input key, input fresh_code, output ready);
endinterface

/* hdl/kclc_out_if.sv */
// ---------------------------------------------------------------------------
// Keypad code lock result channel
// One result beat per key: status, door flag, failure count, entry progress.
// ---------------------------------------------------------------------------
interface kclc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       door_open;
	logic [3:0] failed_count;
	logic [2:0] digits_entered;

	modport source (output valid, output status, output door_open,
		output failed_count, output digits_entered, input ready);
	modport sink   (input valid, input status, input door_open,
		input failed_count, input digits_entered, output ready);
endinterface

/* hdl/kclc_step.sv */
// ---------------------------------------------------------------------------
// Keypad code lock step logic
// Next lock state and status for one key, purely combinational.
// ---------------------------------------------------------------------------
module kclc_step #(
	parameter int CODE_DIGITS = 4
) (
	input  logic [kclc_pkg::KEY_W-1:0]  key,
	input  logic [kclc_pkg::CODE_W-1:0] fresh_code,
	input  logic [kclc_pkg::CODE_W-1:0] emerg_code,
	input  logic [kclc_pkg::FAIL_W-1:0] limit,
	input  kclc_pkg::lock_state_t       cur,
	output kclc_pkg::lock_state_t       nxt,
	output kclc_pkg::status_t           status
);

	localparam logic [kclc_pkg::DCNT_W-1:0] LAST_DIGIT =
		kclc_pkg::DCNT_W'(CODE_DIGITS - 1);

	logic                        lim_hit;
	logic                        finishing;
	logic                        match;
	logic [kclc_pkg::CODE_W-1:0] shifted;
	logic [kclc_pkg::CODE_W-1:0] target;
	logic [kclc_pkg::FAIL_W-1:0] fails_inc;

	// shared terms
	assign lim_hit   = cur.fails > limit;
	assign shifted   = {cur.entry[kclc_pkg::CODE_W-kclc_pkg::KEY_W-1:0], key};
	assign finishing = (cur.mode != kclc_pkg::M_IDLE) && (cur.dcnt == LAST_DIGIT);
	assign fails_inc = (cur.fails == kclc_pkg::FAIL_MAX) ? cur.fails
		: cur.fails + kclc_pkg::FAIL_W'(1);

	// code the finished entry is checked against
	always_comb begin
		unique case (cur.mode)
			kclc_pkg::M_OTP, kclc_pkg::M_DOTP: target = cur.expect_code;
			kclc_pkg::M_EMERG:                 target = emerg_code;
			default:                           target = cur.stored;
		endcase
	end
	assign match = (shifted == target);

	// next state
	always_comb begin
		nxt = cur;
		if (cur.mode == kclc_pkg::M_IDLE) begin
			case (key)
				kclc_pkg::KEY_A: begin
					if (!cur.door && !lim_hit) begin
						nxt.expect_code = fresh_code;
						nxt.mode        = kclc_pkg::M_OTP;
						nxt.dcnt        = '0;
						nxt.entry       = '0;
					end
				end
				kclc_pkg::KEY_B: begin
					if (!cur.door) begin
						nxt.mode  = kclc_pkg::M_EMERG;
						nxt.dcnt  = '0;
						nxt.entry = '0;
					end
				end
				kclc_pkg::KEY_C: begin
					if (!lim_hit) begin
						nxt.mode  = kclc_pkg::M_CURPASS;
						nxt.dcnt  = '0;
						nxt.entry = '0;
					end
				end
				kclc_pkg::KEY_D: begin
					nxt.expect_code = fresh_code;
					nxt.mode        = kclc_pkg::M_DOTP;
					nxt.dcnt        = '0;
					nxt.entry       = '0;
				end
				kclc_pkg::KEY_HASH: nxt.door = 1'b0;
				default: ;
			endcase
		end else if (!finishing) begin
			nxt.entry = shifted;
			nxt.dcnt  = cur.dcnt + kclc_pkg::DCNT_W'(1);
		end else begin
			// entry complete: evaluate, clear the entry, then go idle or to the follow-on mode
			nxt.mode  = kclc_pkg::M_IDLE;
			nxt.dcnt  = '0;
			nxt.entry = '0;
			unique case (cur.mode)
				kclc_pkg::M_OTP, kclc_pkg::M_EMPASS: begin
					if (match) begin
						nxt.fails = '0;
						nxt.door  = 1'b1;
					end else begin
						nxt.fails = fails_inc;
					end
				end
				kclc_pkg::M_EMERG: begin
					if (match) begin
						nxt.fails = '0;
						nxt.mode  = kclc_pkg::M_EMPASS;
					end else begin
						nxt.fails = fails_inc;
					end
				end
				kclc_pkg::M_CURPASS: begin
					if (match) nxt.mode = kclc_pkg::M_NEWC;
					else nxt.fails = fails_inc;
				end
				kclc_pkg::M_DOTP: begin
					if (match) begin
						nxt.fails = '0;
						nxt.mode  = kclc_pkg::M_NEWD;
					end else begin
						nxt.fails = fails_inc;
					end
				end
				default: nxt.stored = shifted;   // new code sessions
			endcase
		end
	end

	// status
	always_comb begin
		status = kclc_pkg::ST_NONE;
		if (cur.mode == kclc_pkg::M_IDLE) begin
			case (key)
				kclc_pkg::KEY_A:
					if (!cur.door && lim_hit) status = kclc_pkg::ST_LOCKOUT;
				kclc_pkg::KEY_C:
					if (lim_hit) status = kclc_pkg::ST_LOCKOUT;
				kclc_pkg::KEY_HASH: status = kclc_pkg::ST_LOCKED;
				default: ;
			endcase
		end else if (finishing) begin
			unique case (cur.mode)
				kclc_pkg::M_OTP, kclc_pkg::M_EMPASS:
					status = match ? kclc_pkg::ST_UNLOCK : kclc_pkg::ST_WRONG;
				kclc_pkg::M_EMERG:
					status = match ? kclc_pkg::ST_EMOK : kclc_pkg::ST_WRONG;
				kclc_pkg::M_CURPASS, kclc_pkg::M_DOTP:
					status = match ? kclc_pkg::ST_NEWPASS : kclc_pkg::ST_WRONG;
				default: status = kclc_pkg::ST_CHANGED;
			endcase
		end
	end

endmodule

/* hdl/keypad_code_lock_controller_unit.sv */
// ---------------------------------------------------------------------------
// Keypad code lock controller
// Session state, configuration registers and the result register.
// ---------------------------------------------------------------------------
// Takes one key beat per clock unless stalled; returns exactly one result
// beat per key from the result register in the next cycle. The lock state
// is updated at the edge that accepts the key, so keys can follow each
// other in every cycle; the input stalls only while a result waits in the
// result register and the sink holds ready low. Configuration writes
// (emergency code at index 0, attempt limit at index 1) take effect at the
// edge of the write and are meant to happen while no key is in flight.
`include "keypad_code_lock_controller_unit_defines.svh"

module keypad_code_lock_controller_unit #(
	parameter int CODE_DIGITS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	kclc_in_if.sink                        in_ch,
	kclc_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [kclc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [kclc_pkg::CFG_DAT_W-1:0] cfg_wdata
);

	kclc_pkg::lock_state_t       st_q;
	kclc_pkg::lock_state_t       st_nxt;
	kclc_pkg::status_t           step_status;
	logic [kclc_pkg::CODE_W-1:0] emerg_q;
	logic [kclc_pkg::FAIL_W-1:0] limit_q;
	logic                        in_fire;

	logic                        out_valid_q;
	kclc_pkg::status_t           out_status_q;
	logic                        out_door_q;
	logic [kclc_pkg::FAIL_W-1:0] out_fails_q;
	logic [kclc_pkg::DCNT_W-1:0] out_dcnt_q;

	// handshake
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emerg_q <= kclc_pkg::EMERG_RST;
			limit_q <= kclc_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				kclc_pkg::REG_EMERG: emerg_q <= cfg_wdata;
				kclc_pkg::REG_LIMIT: limit_q <= cfg_wdata[kclc_pkg::FAIL_W-1:0];
			endcase
		end
	end

	kclc_step #(
		.CODE_DIGITS (CODE_DIGITS)
	) u_step (
		.key        (in_ch.key),
		.fresh_code (in_ch.fresh_code),
		.emerg_code (emerg_q),
		.limit      (limit_q),
		.cur        (st_q),
		.nxt        (st_nxt),
		.status     (step_status)
	);

	// lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode        <= kclc_pkg::M_IDLE;
			st_q.dcnt        <= '0;
			st_q.entry       <= '0;
			st_q.expect_code <= '0;
			st_q.stored      <= kclc_pkg::STORED_RST;
			st_q.fails       <= '0;
			st_q.door        <= 1'b0;
		end else if (in_fire) begin
			st_q <= st_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_status_q <= step_status;
			out_door_q   <= st_nxt.door;
			out_fails_q  <= st_nxt.fails;
			out_dcnt_q   <= st_nxt.dcnt;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = out_status_q;
	assign out_ch.door_open      = out_door_q;
	assign out_ch.failed_count   = out_fails_q;
	assign out_ch.digits_entered = out_dcnt_q;

	// checks
	`KCLC_ASSERT(a_open_means_unlock, clk, arst_n,
		(in_fire && !st_q.door && st_nxt.door) |=> (out_ch.status == kclc_pkg::ST_UNLOCK),
		"door opened without an unlock status")
	`KCLC_ASSERT(a_fail_means_wrong, clk, arst_n,
		(in_fire && (st_nxt.fails > st_q.fails)) |-> (step_status == kclc_pkg::ST_WRONG),
		"failure count rose without a wrong status")
	`KCLC_ASSERT(a_code_change, clk, arst_n,
		(in_fire && (st_nxt.stored != st_q.stored)) |-> (step_status == kclc_pkg::ST_CHANGED),
		"stored code changed without a changed status")
	`KCLC_ASSERT_NEVER(a_idle_count, clk, arst_n,
		(st_q.mode == kclc_pkg::M_IDLE) && (st_q.dcnt != '0),
		"keys counted outside a session")
	`KCLC_ASSERT(a_ready_when_empty, clk, arst_n,
		!out_valid_q |-> in_ch.ready,
		"input stalled with an empty result register")

endmodule
